@@ sv/multiplicative_persistence_record_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the multiplicative persistence record core.
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef MULTIPLICATIVE_PERSISTENCE_RECORD_CORE_ASSERT_SVH
`define MULTIPLICATIVE_PERSISTENCE_RECORD_CORE_ASSERT_SVH

// Same-cycle implication.
`define MPR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/mpr_pkg.sv @@
// ----------------------------------------------------------------------------
// mpr_pkg
// Shared constants and controller/datapath link types.
// ----------------------------------------------------------------------------
package mpr_pkg;

  localparam int NUMBER_WIDTH_DEF = 64;
  localparam int PERSIST_W        = 4;
  localparam logic [PERSIST_W-1:0] PERSIST_MAX = 4'd15;
  localparam int DIGIT_BASE       = 10;
  localparam int BITS_PER_STEP    = 4;  // binary bits folded into BCD per cycle

  // controller -> datapath
  typedef struct packed {
    logic take;        // input ready, load on accept
    logic conv_start;  // load shifter, clear BCD, product := 1
    logic conv_step;   // fold next binary bits into BCD
    logic mult_step;   // multiply product by lowest digit
    logic round_end;   // last digit of this round: value := product
    logic finish;      // load result word, update record
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_valid;
    logic v_small;     // value below the base
    logic digit_last;  // no significant digits above the lowest
    logic out_free;    // result register can take a word
  } status_t;

endpackage

@@ sv/mpr_if.sv @@
// ----------------------------------------------------------------------------
// mpr_item_if / mpr_result_if
// Valid/ready channels for input numbers and persistence results.
// ----------------------------------------------------------------------------
interface mpr_item_if #(
  parameter int NUMBER_WIDTH = mpr_pkg::NUMBER_WIDTH_DEF
);
  logic                    valid;
  logic                    ready;
  logic [NUMBER_WIDTH-1:0] number;
  logic                    clear_record;

  modport source (output valid, number, clear_record, input ready);
  modport sink   (input valid, number, clear_record, output ready);
endinterface

interface mpr_result_if;
  logic                            valid;
  logic                            ready;
  logic [mpr_pkg::PERSIST_W-1:0]   persistence;
  logic                            new_record;

  modport source (output valid, persistence, new_record, input ready);
  modport sink   (input valid, persistence, new_record, output ready);
endinterface

@@ sv/mpr_ctrl.sv @@
// ----------------------------------------------------------------------------
// mpr_ctrl
// Sequencer: rounds of binary-to-BCD conversion then digit multiplication.
// ----------------------------------------------------------------------------
module mpr_ctrl #(
  parameter int NUMBER_WIDTH = mpr_pkg::NUMBER_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  mpr_pkg::status_t status,
  output mpr_pkg::cmd_t    cmd
);

  localparam int NSTEP = (NUMBER_WIDTH + mpr_pkg::BITS_PER_STEP - 1) / mpr_pkg::BITS_PER_STEP;
  localparam int CW    = $clog2(NSTEP);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_CONV   = 5'b00100,
    S_MULT   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] step, step_next;

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.take = 1'b1;
        if (status.in_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (status.v_small) begin
          state_next = S_FINISH;
        end else begin
          cmd.conv_start = 1'b1;
          step_next      = '0;
          state_next     = S_CONV;
        end
      end
      S_CONV: begin
        cmd.conv_step = 1'b1;
        step_next     = step + 1'b1;
        if (step == CW'(NSTEP - 1)) state_next = S_MULT;
      end
      S_MULT: begin
        cmd.mult_step = 1'b1;
        if (status.digit_last) begin
          cmd.round_end = 1'b1;
          state_next    = S_CHECK;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

@@ sv/mpr_dp.sv @@
// ----------------------------------------------------------------------------
// mpr_dp
// Datapath: value, double-dabble BCD converter, digit product, record.
// ----------------------------------------------------------------------------
module mpr_dp #(
  parameter int NUMBER_WIDTH = mpr_pkg::NUMBER_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  mpr_item_if.sink           item_in,
  mpr_result_if.source       result_out,
  input  mpr_pkg::cmd_t      cmd,
  output mpr_pkg::status_t   status
);

  localparam int PW     = mpr_pkg::PERSIST_W;
  localparam int BPS    = mpr_pkg::BITS_PER_STEP;
  localparam int NSTEP  = (NUMBER_WIDTH + BPS - 1) / BPS;
  localparam int SW     = NSTEP * BPS;
  // decimal digits of the largest value: floor(W*log10(2)) + 1
  localparam int DIGITS = (NUMBER_WIDTH * 30103) / 100000 + 1;
  localparam int BW     = 4 * DIGITS;

  logic [NUMBER_WIDTH-1:0] v;
  logic [NUMBER_WIDTH-1:0] prod;
  logic [NUMBER_WIDTH-1:0] prod_next;
  logic [SW-1:0]           sh;
  logic [SW-1:0]           sh_conv;
  logic [BW-1:0]           bcd;
  logic [BW-1:0]           bcd_conv;
  logic [PW-1:0]           count;
  logic [PW-1:0]           best;
  logic                    out_valid;
  logic [PW-1:0]           out_persistence;
  logic                    out_new_record;
  logic                    is_record;

  // double dabble, BPS bits per cycle
  always_comb begin
    bcd_conv = bcd;
    sh_conv  = sh;
    for (int k = 0; k < BPS; k++) begin
      for (int d = 0; d < DIGITS; d++) begin
        if (bcd_conv[4*d +: 4] >= 4'd5) bcd_conv[4*d +: 4] = bcd_conv[4*d +: 4] + 4'd3;
      end
      bcd_conv = {bcd_conv[BW-2:0], sh_conv[SW-1]};
      sh_conv  = {sh_conv[SW-2:0], 1'b0};
    end
  end

  // product by the lowest digit; wraps harmlessly, the true product fits
  assign prod_next = NUMBER_WIDTH'(prod * bcd[3:0]);
  assign is_record = count > best;

  assign status.in_valid   = item_in.valid;
  assign status.v_small    = v < NUMBER_WIDTH'(mpr_pkg::DIGIT_BASE);
  assign status.digit_last = (bcd >> 4) == '0;
  assign status.out_free   = !out_valid || result_out.ready;

  assign item_in.ready          = cmd.take;
  assign result_out.valid       = out_valid;
  assign result_out.persistence = out_persistence;
  assign result_out.new_record  = out_new_record;

  always_ff @(posedge clk) begin
    if (cmd.take && item_in.valid) begin
      v <= item_in.number;
    end else if (cmd.round_end) begin
      v <= prod_next;
    end
    if (cmd.conv_start) begin
      sh   <= SW'(v);
      bcd  <= '0;
      prod <= NUMBER_WIDTH'(1);
    end else if (cmd.conv_step) begin
      sh  <= sh_conv;
      bcd <= bcd_conv;
    end else if (cmd.mult_step) begin
      bcd  <= bcd >> 4;
      prod <= prod_next;
    end
    if (cmd.finish) begin
      out_persistence <= count;
      out_new_record  <= is_record;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      best      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.take && item_in.valid) begin
        count <= '0;
        if (item_in.clear_record) best <= '0;
      end else if (cmd.round_end && count != mpr_pkg::PERSIST_MAX) begin
        count <= count + 1'b1;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
        if (is_record) best <= count;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ sv/multiplicative_persistence_record_core.sv @@
// ----------------------------------------------------------------------------
// multiplicative_persistence_record_core
// Takes one number per word and returns its multiplicative persistence
// (saturating at 15) and whether it beats the best seen since reset or the
// last clear_record. One word is worked at a time. Each round runs a value
// check, the double-dabble converter (four bits a cycle) and the digit
// multiplier, which works through the significant decimal digits from the
// lowest up; each item also has an accept state, a final check and a result
// state. The result register lets a new number be taken while the last
// result waits.
// ----------------------------------------------------------------------------
`include "multiplicative_persistence_record_core_assert.svh"

module multiplicative_persistence_record_core #(
  parameter int NUMBER_WIDTH = mpr_pkg::NUMBER_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  mpr_item_if.sink     item_in,
  mpr_result_if.source result_out
);

  mpr_pkg::cmd_t    cmd;
  mpr_pkg::status_t status;

  mpr_ctrl #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  mpr_dp #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_in),
    .result_out (result_out),
    .cmd        (cmd),
    .status     (status)
  );

  `MPR_ASSERT_NEXT(a_busy_after_accept, item_in.valid && item_in.ready, !item_in.ready, "accepted a word while busy")
  `MPR_ASSERT_NOW(a_cmd_exclusive, 1'b1, $onehot0({cmd.take, cmd.conv_start, cmd.conv_step, cmd.mult_step, cmd.finish}), "conflicting datapath commands")
  `MPR_ASSERT_NOW(a_record_nonzero, result_out.valid && result_out.new_record, result_out.persistence != '0, "record with zero persistence")
  `MPR_ASSERT_NOW(a_result_from_finish, $rose(result_out.valid), $past(cmd.finish), "result word without finish")

endmodule

@@ verif/mpr_checker.sv @@
// ----------------------------------------------------------------------------
// mpr_checker
// Watches the number and result channels of the persistence record core. For
// each accepted number it works out the persistence and record flag the core
// should return, then compares every accepted result word with the oldest
// outstanding expectation. Counts failures and exposes the number of results
// still owed.
// ----------------------------------------------------------------------------
module mpr_checker #(
  parameter int NUMBER_WIDTH = mpr_pkg::NUMBER_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  mpr_item_if         item_mon,
  mpr_result_if       result_mon,
  output int unsigned fail_count,
  output int unsigned backlog
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [mpr_pkg::PERSIST_W-1:0] persistence;
    logic                          new_record;
  } persist_word_t;

  persist_word_t                 owed_q[$];
  logic [mpr_pkg::PERSIST_W-1:0] best_seen = '0;
  int unsigned                   mismatches = 0;
  int unsigned                   owed_count = 0;

  assign fail_count = mismatches;
  assign backlog    = owed_count;

  // rounds of digit products until the value is a single digit, saturating
  function automatic logic [mpr_pkg::PERSIST_W-1:0] digit_rounds(
    input logic [NUMBER_WIDTH-1:0] num
  );
    logic [63:0]                   val;
    logic [63:0]                   rest;
    logic [63:0]                   prod;
    logic [mpr_pkg::PERSIST_W-1:0] rounds;
    val    = 64'(num);
    rounds = '0;
    while (val >= 64'(mpr_pkg::DIGIT_BASE)) begin
      prod = 64'd1;
      rest = val;
      while (rest != 64'd0) begin
        prod = prod * (rest % 64'(mpr_pkg::DIGIT_BASE));
        rest = rest / 64'(mpr_pkg::DIGIT_BASE);
      end
      val = prod;
      if (rounds != mpr_pkg::PERSIST_MAX) rounds = rounds + 1'b1;
    end
    return rounds;
  endfunction

  always @(posedge clk) begin : watch
    persist_word_t                 want;
    persist_word_t                 got;
    logic [mpr_pkg::PERSIST_W-1:0] rounds;
    logic [mpr_pkg::PERSIST_W-1:0] bar;
    if (rst) begin
      best_seen <= '0;
    end else begin
      // results first: nothing the core returns can stem from a word taken this edge
      if (result_mon.valid && result_mon.ready) begin
        got.persistence = result_mon.persistence;
        got.new_record  = result_mon.new_record;
        if (owed_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result persistence=%0d new_record=%0b",
                     $time, got.persistence, got.new_record);
        end else begin
          want = owed_q.pop_front();
          if (got.persistence !== want.persistence || got.new_record !== want.new_record) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result mismatch: persistence exp %0d got %0d, new_record exp %0b got %0b",
                       $time, want.persistence, got.persistence, want.new_record, got.new_record);
          end
        end
      end
      if (item_mon.valid && item_mon.ready) begin
        bar    = item_mon.clear_record ? '0 : best_seen;
        rounds = digit_rounds(item_mon.number);
        want.persistence = rounds;
        want.new_record  = rounds > bar;
        owed_q = {owed_q, want};
        best_seen <= want.new_record ? rounds : bar;
      end
      owed_count <= owed_q.size();
    end
  end

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Regression for the multiplicative persistence record core. Drives a short
// directed run over the persistence records, small values, zero digits and
// record clears, then random numbers: mostly digit chains with few zeros that
// reach high persistence, with full-width and small values mixed in. The
// sender works in bursts, the receiver stalls in phases; the checker beside
// the core predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_WORDS = 1825;
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int unsigned DRAIN_CYCLES = 450;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic [63:0] in_number = '0;
  logic        in_clear  = 1'b0;
  logic        rx_ready  = 1'b0;

  int unsigned fail_count;
  int unsigned backlog;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;
  int unsigned stall_mode  = 0;
  int unsigned stall_left  = 0;

  mpr_item_if   item_ch();
  mpr_result_if result_ch();

  assign item_ch.valid        = in_valid;
  assign item_ch.number       = in_number;
  assign item_ch.clear_record = in_clear;
  assign result_ch.ready      = rx_ready;

  multiplicative_persistence_record_core dut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_ch),
    .result_out (result_ch)
  );

  mpr_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .item_mon   (item_ch),
    .result_mon (result_ch),
    .fail_count (fail_count),
    .backlog    (backlog)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("multiplicative_persistence_record_core regression: fail");
      $finish;
    end
  end

  // receiver: phases of always ready, light stalls and heavy stalls
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 400);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0, 1:    rx_ready <= 1'b1;
      2:       rx_ready <= ($urandom_range(0, 3) != 0);
      default: rx_ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  // hold one word on the channel until it is taken; gaps between bursts
  task automatic send_word(input logic [63:0] num, input logic clr);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) :
                                                 $urandom_range(1, 20);
    end
    in_valid  <= 1'b1;
    in_number <= num;
    in_clear  <= clr;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    burst_left--;
  endtask

  initial begin : stimulus
    logic [63:0] num;
    logic [3:0]  digit;
    int unsigned kind;
    int unsigned len;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: small values, each persistence record, zero digits, clears
    send_word(64'd0, 1'b0);
    send_word(64'd9, 1'b0);
    send_word(64'd10, 1'b0);
    send_word(64'd25, 1'b0);
    send_word(64'd25, 1'b0);
    send_word(64'd39, 1'b0);
    send_word(64'd77, 1'b0);
    send_word(64'd679, 1'b0);
    send_word(64'd6788, 1'b0);
    send_word(64'd68889, 1'b0);
    send_word(64'd2677889, 1'b0);
    send_word(64'd26888999, 1'b0);
    send_word(64'd3778888999, 1'b0);
    send_word(64'd277777788888899, 1'b0);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_word(64'd0, 1'b1);
    send_word(64'd39, 1'b1);
    send_word(64'd100, 1'b0);
    send_word(64'h8000_0000_0000_0000, 1'b0);
    send_word(64'h5555_5555_5555_5555, 1'b0);
    send_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_word(64'd277777788888899, 1'b0);
    send_word(64'd277777788888899, 1'b0);
    send_word(64'd1, 1'b1);

    for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        num = {$urandom, $urandom};
      end else if (kind < 45) begin
        num = 64'($urandom_range(0, 999));
      end else begin
        // digit chains mostly without zeros or fives survive many rounds
        len = $urandom_range(2, 19);
        num = '0;
        for (int unsigned d = 0; d < len; d++) begin
          case ($urandom_range(0, 11))
            0:       digit = 4'd2;
            1:       digit = 4'd3;
            2:       digit = 4'd4;
            3:       digit = 4'd6;
            4, 5:    digit = 4'd7;
            6, 7:    digit = 4'd8;
            8, 9:    digit = 4'd9;
            10:      digit = 4'($urandom_range(0, 9));
            default: digit = 4'd1;
          endcase
          num = num * 64'd10 + 64'(digit);
        end
      end
      send_word(num, $urandom_range(0, 15) == 0);
    end
    in_valid <= 1'b0;

    // let the checker count the last word before watching the backlog
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && backlog == 0) begin
      $display("multiplicative_persistence_record_core regression: pass");
    end else begin
      $display("multiplicative_persistence_record_core regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/mpr_pkg.sv
sv/mpr_if.sv
sv/mpr_ctrl.sv
sv/mpr_dp.sv
sv/multiplicative_persistence_record_core.sv
verif/mpr_checker.sv
verif/tb_top.sv
